// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the tape processor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define TAPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TAPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TAPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tape_pkg.sv =====
package tape_pkg;

  // request types
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_PEEK = 2'd2
  } tape_req_t;

  // instruction opcodes
  typedef enum logic [1:0] {
    OP_RIGHT = 2'd0,
    OP_ADD   = 2'd1,
    OP_BNZ   = 2'd2,
    OP_NONE  = 2'd3
  } tape_op_t;

  // source of the address under range check
  typedef enum logic [1:0] {
    SEL_ADDR = 2'd0,
    SEL_PC   = 2'd1,
    SEL_DP   = 2'd2
  } tape_sel_t;

  localparam int unsigned CfgWidth = 17;
  localparam logic [CfgWidth-1:0] CfgReset = 17'h10000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] word_address;
    logic [31:0] load_value;
  } tape_in_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [31:0] pc_now;
    logic [31:0] dp_now;
    logic [1:0]  op_done;
    logic        fault;
  } tape_out_t;

  // controller to datapath
  typedef struct packed {
    logic      latch_req;
    tape_sel_t chk_sel;
    logic      xfer_start;
    logic      load_wdata;
    logic      wdata_sum;
    logic      rd_run;
    logic      wr_run;
    logic      set_halt;
    logic      take_instr;
    logic      dp_add;
    logic      pc_add;
    logic      res_clear;
    logic      res_peek;
    logic      out_load;
  } tape_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       range_ok;
    logic       halted;
    tape_op_t   opcode;
    logic       data_nz;
    logic       rd_last;
    logic       wr_last;
    logic       out_free;
  } tape_stat_t;

endpackage

// ===== rtl/tape_ram.sv =====
module tape_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tape_ctrl.sv =====
`include "assert_macros.svh"

module tape_ctrl
  import tape_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tape_stat_t st_i,
  output tape_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_FETCH  = 11'b00000000100,
    S_TAKE   = 11'b00000001000,
    S_EXEC   = 11'b00000010000,
    S_OPND   = 11'b00000100000,
    S_APPLY  = 11'b00001000000,
    S_PEEK   = 11'b00010000000,
    S_PWORD  = 11'b00100000000,
    S_WRITE  = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } tape_state_t;

  tape_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    cmd_o.chk_sel = SEL_ADDR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.latch_req = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_clear = 1'b1;
        case (st_i.req_type)
          REQ_LOAD: begin
            if (st_i.range_ok) begin
              cmd_o.xfer_start = 1'b1;
              cmd_o.load_wdata = 1'b1;
              state_nxt = S_WRITE;
            end else begin
              cmd_o.set_halt = 1'b1;
              state_nxt = S_RESP;
            end
          end
          REQ_PEEK: begin
            if (st_i.range_ok) begin
              cmd_o.xfer_start = 1'b1;
              state_nxt = S_PEEK;
            end else begin
              cmd_o.set_halt = 1'b1;
              state_nxt = S_RESP;
            end
          end
          REQ_STEP: begin
            cmd_o.chk_sel = SEL_PC;
            if (st_i.halted) begin
              state_nxt = S_RESP;
            end else if (st_i.range_ok) begin
              cmd_o.xfer_start = 1'b1;
              state_nxt = S_FETCH;
            end else begin
              cmd_o.set_halt = 1'b1;
              state_nxt = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FETCH: begin
        cmd_o.rd_run = 1'b1;
        if (st_i.rd_last) begin
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.take_instr = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.chk_sel = SEL_DP;
        case (st_i.opcode)
          OP_RIGHT: begin
            cmd_o.dp_add = 1'b1;
            state_nxt = S_RESP;
          end
          OP_ADD, OP_BNZ: begin
            if (st_i.range_ok) begin
              cmd_o.xfer_start = 1'b1;
              state_nxt = S_OPND;
            end else begin
              cmd_o.set_halt = 1'b1;
              state_nxt = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_OPND: begin
        cmd_o.rd_run = 1'b1;
        if (st_i.rd_last) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.chk_sel = SEL_DP;
        if (st_i.opcode == OP_ADD) begin
          cmd_o.xfer_start = 1'b1;
          cmd_o.load_wdata = 1'b1;
          cmd_o.wdata_sum  = 1'b1;
          state_nxt = S_WRITE;
        end else begin
          cmd_o.pc_add = st_i.data_nz;
          state_nxt = S_RESP;
        end
      end
      S_PEEK: begin
        cmd_o.rd_run = 1'b1;
        if (st_i.rd_last) begin
          state_nxt = S_PWORD;
        end
      end
      S_PWORD: begin
        cmd_o.res_peek = 1'b1;
        state_nxt = S_RESP;
      end
      S_WRITE: begin
        cmd_o.wr_run = 1'b1;
        if (st_i.wr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a transfer only starts on an address that passed the bound test
  `TAPE_ASSERT_IMPL(a_start_in_range, cmd_o.xfer_start, st_i.range_ok, "transfer started out of range")
  // memory reads and writes never overlap
  `TAPE_ASSERT(a_no_rd_wr, !(cmd_o.rd_run && cmd_o.wr_run), "read and write run together")

endmodule

// ===== rtl/tape_dp.sv =====
`include "assert_macros.svh"

module tape_dp
  import tape_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tape_cmd_t           cmd_i,
  output tape_stat_t          st_o,
  input  tape_in_t            in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tape_out_t           out_data_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [32:0] MemBytesW = 33'(MEM_BYTES);

  tape_in_t            req_r;
  logic [31:0]         pc_r, pc_nxt;
  logic [31:0]         dp_r, dp_nxt;
  logic                halted_r;
  logic [CfgWidth-1:0] size_r;
  logic [31:0]         instr_r;
  logic [31:0]         data_r, data_nxt;
  logic [AW-1:0]       mem_addr_r;
  logic [2:0]          cnt_r;
  logic [31:0]         res_word_r;
  tape_op_t            res_op_r;
  logic                out_valid_r;
  tape_out_t           out_r;

  logic [31:0] imm;
  logic [31:0] chk_addr;
  logic [32:0] chk_sum;
  logic [32:0] size_ext;
  logic [32:0] size_eff;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;

  assign imm = {{2{instr_r[29]}}, instr_r[29:0]};

  // bound test: addr + 3 < min(size register, memory size)
  always_comb begin
    case (cmd_i.chk_sel)
      SEL_PC:  chk_addr = pc_r;
      SEL_DP:  chk_addr = dp_r;
      default: chk_addr = {16'h0000, req_r.word_address};
    endcase
  end

  assign size_ext = {{(33-CfgWidth){1'b0}}, size_r};
  assign size_eff = (size_ext > MemBytesW) ? MemBytesW : size_ext;
  assign chk_sum  = {1'b0, chk_addr} + 33'd3;

  // request and configuration registers
  always_ff @(posedge clk) begin
    if (cmd_i.latch_req) begin
      req_r <= in_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CfgReset;
    end else if (cfg_we_i) begin
      size_r <= cfg_data_i;
    end
  end

  // architectural state
  always_comb begin
    pc_nxt = pc_r;
    if (cmd_i.take_instr) begin
      pc_nxt = pc_r + 32'd4;
    end else if (cmd_i.pc_add) begin
      pc_nxt = pc_r + imm;
    end
  end

  assign dp_nxt = cmd_i.dp_add ? (dp_r + imm) : dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      dp_r     <= '0;
      halted_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      dp_r <= dp_nxt;
      if (cmd_i.set_halt) begin
        halted_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take_instr) begin
      instr_r <= data_r;
    end
  end

  // byte-serial transfer engine: data_r assembles reads and drains writes
  always_comb begin
    data_nxt = data_r;
    if (cmd_i.xfer_start && cmd_i.load_wdata) begin
      data_nxt = cmd_i.wdata_sum ? (data_r + imm) : req_r.load_value;
    end else if (cmd_i.rd_run && (cnt_r != 3'd0)) begin
      data_nxt = {data_r[23:0], ram_rdata};
    end else if (cmd_i.wr_run) begin
      data_nxt = {data_r[23:0], 8'h00};
    end
  end

  assign ram_re = cmd_i.rd_run && !cnt_r[2];
  assign ram_we = cmd_i.wr_run;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd_i.xfer_start) begin
      mem_addr_r <= chk_addr[AW-1:0];
      cnt_r      <= 3'd0;
    end else if (cmd_i.rd_run || cmd_i.wr_run) begin
      cnt_r <= cnt_r + 3'd1;
      if (ram_re || ram_we) begin
        mem_addr_r <= mem_addr_r + AW'(1);
      end
    end
  end

  tape_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (mem_addr_r),
    .wdata (data_r[31:24]),
    .rdata (ram_rdata)
  );

  // result word and opcode
  always_ff @(posedge clk) begin
    if (cmd_i.res_clear) begin
      res_word_r <= '0;
      res_op_r   <= OP_NONE;
    end else if (cmd_i.take_instr) begin
      res_word_r <= data_r;
      res_op_r   <= tape_op_t'(data_r[31:30]);
    end else if (cmd_i.res_peek) begin
      res_word_r <= data_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_r.read_word <= res_word_r;
      out_r.pc_now    <= pc_r;
      out_r.dp_now    <= dp_r;
      out_r.op_done   <= 2'(res_op_r);
      out_r.fault     <= halted_r;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

  // status back to the controller
  always_comb begin
    st_o          = '0;
    st_o.req_type = req_r.req_type;
    st_o.range_ok = (chk_sum < size_eff);
    st_o.halted   = halted_r;
    st_o.opcode   = tape_op_t'(instr_r[31:30]);
    st_o.data_nz  = (data_r != 32'd0);
    st_o.rd_last  = (cnt_r == 3'd4);
    st_o.wr_last  = (cnt_r == 3'd3);
    st_o.out_free = !out_valid_r || out_ready_i;
  end

  // halted is sticky
  `TAPE_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halted flag cleared")
  // every byte write lands inside the active size
  `TAPE_ASSERT_IMPL(a_wr_bound, ram_we, (33'(mem_addr_r) < size_eff), "write beyond size")

endmodule

// ===== rtl/three_op_tape_processor.sv =====
// One request at a time: the next is taken once the result is registered and
// the controller is back in idle. Memory is a single byte-wide port, so every
// word moves one byte at a time.
// Reset (rst_n low, synchronous): pc, dp, halted cleared, size 65536, memory kept.
`include "assert_macros.svh"

module three_op_tape_processor
  import tape_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tape_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tape_out_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgWidth-1:0] cfg_data
);

  tape_cmd_t  cmd;
  tape_stat_t st;

  // size register is always writable
  assign cfg_ready = 1'b1;

  tape_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  tape_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_valid),
    .cfg_data_i  (cfg_data),
    .out_ready_i (out_ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  // one request in flight: ready drops right after an accept
  `TAPE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken")

endmodule
